### sv/yuyv_to_rgb565_stream_macros.svh
// assertion macros for the yuyv to rgb565 stream rtl, used by y2r_emit
`ifndef YUYV_TO_RGB565_STREAM_MACROS_SVH
`define YUYV_TO_RGB565_STREAM_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled during reset
`define Y2R_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("y2r assertion failed");

// next-cycle implication, disabled during reset
`define Y2R_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("y2r assertion failed");

`else

`define Y2R_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define Y2R_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

### sv/y2r_pkg.sv
// types and conversion functions for the yuyv to rgb565 stream
`default_nettype none

package y2r_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_frame;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] first_byte;
      logic [7:0] second_byte;
      logic       last_of_pair;
      logic       frame_done;
   } rsp_payload_type;

   // one complete Y0 U Y1 V group, chroma already folded into per-color offsets
   typedef struct packed {
      logic              load;
      logic [7:0]        luma_first;
      logic [7:0]        luma_second;
      logic signed [8:0] red_off;
      logic signed [8:0] green_off;
      logic signed [8:0] blue_off;
      logic              end_of_frame;
   } group_type;

   localparam logic [7:0] CHROMA_BIAS = 8'h80;
   localparam logic signed [15:0] COEF_RV = 16'sd103;
   localparam logic signed [15:0] COEF_GU = 16'sd88;
   localparam logic signed [15:0] COEF_GV = 16'sd183;
   localparam logic signed [15:0] COEF_BU = 16'sd198;
   localparam logic [7:0] GREEN_MID_MASK = 8'h1C;
   localparam logic [7:0] BLUE_MASK = 8'hF8;

   // signed chroma times constant, floor divided by 256
   function automatic logic signed [7:0] scale_chroma(logic signed [7:0] c,
                                                      logic signed [15:0] k);
      logic signed [15:0] prod;
      prod = 16'(c) * k;
      return $signed(prod[15:8]);
   endfunction

   function automatic logic [7:0] clamp_u8(logic signed [9:0] x);
      logic [7:0] res;
      if (x < 10'sd0) begin
         res = 8'd0;
      end else if (x > 10'sd255) begin
         res = 8'd255;
      end else begin
         res = x[7:0];
      end
      return res;
   endfunction

   function automatic rsp_payload_type make_pixel(logic [7:0] y,
                                                  logic signed [8:0] r_off,
                                                  logic signed [8:0] g_off,
                                                  logic signed [8:0] b_off,
                                                  logic last, logic done);
      logic signed [9:0] y_s;
      logic [7:0]        r;
      logic [7:0]        g;
      logic [7:0]        b;
      rsp_payload_type   px;
      y_s = $signed({2'b00, y});
      r = clamp_u8(y_s + 10'(r_off));
      g = clamp_u8(y_s + 10'(g_off));
      b = clamp_u8(y_s + 10'(b_off));
      px.first_byte = ((g & GREEN_MID_MASK) << 3) | (r >> 3);
      px.second_byte = (b & BLUE_MASK) | (g >> 5);
      px.last_of_pair = last;
      px.frame_done = done;
      return px;
   endfunction

endpackage

`default_nettype wire

### sv/y2r_gather.sv
// byte phase tracking, Y0/U/Y1 capture and chroma offset calculation
`default_nettype none

module y2r_gather import y2r_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire req_payload_type req_payload,
   input  wire logic            pair_busy,
   output group_type            group
);

   typedef enum logic [1:0] {PH_Y0, PH_U, PH_Y1, PH_V} phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  luma_first_ff, luma_first_in;
   logic [7:0]  chroma_blue_ff, chroma_blue_in;
   logic [7:0]  luma_second_ff, luma_second_in;
   logic        accept;
   logic signed [7:0] u_s;
   logic signed [7:0] v_s;

   // a V byte waits until the previous pair has left the pair buffer
   assign req_stall = pair_busy && (phase_ff == PH_V);
   assign accept = req_valid && !req_stall;

   assign u_s = $signed(chroma_blue_ff ^ CHROMA_BIAS);
   assign v_s = $signed(req_payload.data_byte ^ CHROMA_BIAS);

   always_comb begin
      phase_in = phase_ff;
      luma_first_in = luma_first_ff;
      chroma_blue_in = chroma_blue_ff;
      luma_second_in = luma_second_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_Y0: begin
               luma_first_in = req_payload.data_byte;
               phase_in = PH_U;
            end
            PH_U: begin
               chroma_blue_in = req_payload.data_byte;
               phase_in = PH_Y1;
            end
            PH_Y1: begin
               luma_second_in = req_payload.data_byte;
               phase_in = PH_V;
            end
            PH_V: begin
               phase_in = PH_Y0;
            end
            default: begin
               phase_in = PH_Y0;
            end
         endcase
         if (req_payload.end_of_frame) begin
            phase_in = PH_Y0;
         end
      end
   end

   always_comb begin
      group.load = accept && (phase_ff == PH_V);
      group.luma_first = luma_first_ff;
      group.luma_second = luma_second_ff;
      group.red_off = 9'(v_s) + 9'(scale_chroma(v_s, COEF_RV));
      group.green_off = 9'sd0 - 9'(scale_chroma(u_s, COEF_GU))
                        - 9'(scale_chroma(v_s, COEF_GV));
      group.blue_off = 9'(u_s) + 9'(scale_chroma(u_s, COEF_BU));
      group.end_of_frame = req_payload.end_of_frame;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_Y0;
      end else begin
         phase_ff <= phase_in;
      end
      luma_first_ff <= luma_first_in;
      chroma_blue_ff <= chroma_blue_in;
      luma_second_ff <= luma_second_in;
   end

endmodule

`default_nettype wire

### sv/y2r_emit.sv
// pair buffer, per-pixel color calculation and result register
`default_nettype none
`include "yuyv_to_rgb565_stream_macros.svh"

module y2r_emit import y2r_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire group_type group,
   output logic           pair_busy,
   output logic           rsp_valid,
   input  wire logic      rsp_stall,
   output rsp_payload_type rsp_payload
);

   logic              pair_valid_ff, pair_valid_in;
   logic              pair_second_ff, pair_second_in;
   logic [7:0]        luma_first_ff, luma_second_ff;
   logic signed [8:0] red_off_ff, green_off_ff, blue_off_ff;
   logic              eof_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_payload_ff, rsp_payload_in;
   logic              out_load;
   logic [7:0]        luma_sel;

   assign pair_busy = pair_valid_ff;
   assign out_load = pair_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign luma_sel = pair_second_ff ? luma_second_ff : luma_first_ff;

   always_comb begin
      pair_valid_in = pair_valid_ff;
      pair_second_in = pair_second_ff;
      if (group.load) begin
         pair_valid_in = 1'b1;
         pair_second_in = 1'b0;
      end else if (out_load) begin
         pair_valid_in = !pair_second_ff;
         pair_second_in = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_payload_in = make_pixel(luma_sel, red_off_ff, green_off_ff, blue_off_ff,
                                     pair_second_ff, pair_second_ff && eof_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_valid_ff <= 1'b0;
         pair_second_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pair_valid_ff <= pair_valid_in;
         pair_second_ff <= pair_second_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (group.load) begin
         luma_first_ff <= group.luma_first;
         luma_second_ff <= group.luma_second;
         red_off_ff <= group.red_off;
         green_off_ff <= group.green_off;
         blue_off_ff <= group.blue_off;
         eof_ff <= group.end_of_frame;
      end
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // a new group never overwrites pixels still waiting in the pair buffer
   `Y2R_ASSERT_IMPLY(a_no_pair_overrun, clock, reset, group.load, !pair_valid_ff)
   // the first pixel of a pair is always followed by its second
   `Y2R_ASSERT_NEXT(a_second_follows, clock, reset, out_load && !pair_second_ff,
                    pair_valid_ff && pair_second_ff)
   // frame end is only flagged on the second pixel
   `Y2R_ASSERT_IMPLY(a_done_on_second, clock, reset,
                     rsp_valid_ff && rsp_payload_ff.frame_done,
                     rsp_payload_ff.last_of_pair)

endmodule

`default_nettype wire

### sv/yuyv_to_rgb565_stream.sv
// YUYV 4:2:2 byte stream to RGB565 byte pair converter, top level
//
// req channel: one camera byte per transaction, in order Y0 U Y1 V, plus an
//   end_of_frame flag that returns the byte phase to Y0 after that byte.
//   A frame end before the V byte drops the partial group.
// rsp channel: one RGB565 pixel per transaction as two packed bytes. Each V
//   byte yields two transactions, the Y0 pixel then the Y1 pixel; frame_done
//   marks the Y1 pixel of a V byte that carried end_of_frame.
// Throughput: one byte per cycle while rsp_stall is low; two pixels per
//   four bytes fit easily through the one-pixel-per-cycle result register.
// Path: a V byte's group is registered in the pair buffer; the Y0 pixel and
//   then the Y1 pixel each enter the result register when rsp_stall allows.
// Stall: req_stall rises only on a V byte while the previous pair is still
//   in the pair buffer, i.e. when rsp_stall holds back the result register.
// Reset: synchronous; the phase returns to Y0 and no results are pending.
`default_nettype none

module yuyv_to_rgb565_stream import y2r_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire req_payload_type req_payload,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output rsp_payload_type      rsp_payload
);

   group_type group;
   logic      pair_busy;

   y2r_gather u_gather (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .pair_busy   (pair_busy),
      .group       (group)
   );

   y2r_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .group       (group),
      .pair_busy   (pair_busy),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire
